// ===== hw/rtl/adl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adl_pkg;

    localparam int ENTRIES   = 8;
    localparam int KEY_BITS  = 32;
    localparam int IDX_BITS  = $clog2(ENTRIES);
    localparam int LINK_BITS = $clog2(ENTRIES + 1);
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);

    // A link equal to ENTRIES marks the end of the list.
    localparam logic [LINK_BITS-1:0] NONE_LINK = LINK_BITS'(ENTRIES);
    localparam logic [IDX_BITS-1:0]  LAST_IDX  = IDX_BITS'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2
    } status_t;

    typedef enum logic {
        MODE_APPEND = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] key_value;
    } in_t;

    typedef struct packed {
        status_t               status;
        logic [IDX_BITS-1:0]   slot;
        logic [CNT_BITS-1:0]   removed_count;
        logic [CNT_BITS-1:0]   length;
    } out_t;

    typedef struct packed {
        logic [LINK_BITS-1:0] next_link;
        logic [LINK_BITS-1:0] prev_link;
    } link_t;

    // Sign-extend the 32-bit key and keep the low KEY_BITS bits.
    function automatic logic [KEY_BITS-1:0] norm_key(input logic [31:0] raw);
        logic [63:0] ext;
        ext = {{32{raw[31]}}, raw};
        return ext[KEY_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/adl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/array_doubly_linked_list.sv =====
// An append goes through S_APP_WR and S_APP_FIX to S_DONE, or straight to S_DONE on a full list;
// a remove visits every entry and unlinks each match through S_UNL_P, S_UNL_WP and S_UNL_WN.
// One item is in flight at a time; the next input beat is taken once the result is parked
// in the output register. Each entry visit reads the key and link memories, then checks the key.
// Reset (aresetn low, synchronous) empties the list: all valid bits clear, head and tail none.
// The key and link memories are not cleared; entries are read only while valid.
`timescale 1ns / 1ps
`default_nettype none

module array_doubly_linked_list (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire adl_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output adl_pkg::out_t     m_data
);

    import adl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_APP_WR   = 9'b000000010,
        S_APP_FIX  = 9'b000000100,
        S_SCAN_RD  = 9'b000001000,
        S_SCAN_CHK = 9'b000010000,
        S_UNL_P    = 9'b000100000,
        S_UNL_WP   = 9'b001000000,
        S_UNL_WN   = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t               state_reg;
    logic                 mode_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic [IDX_BITS-1:0]  slot_reg;
    logic                 full_reg;
    logic [LINK_BITS-1:0] p_reg;
    logic [LINK_BITS-1:0] n_reg;
    logic [CNT_BITS-1:0]  removed_reg;
    logic [LINK_BITS-1:0] head_reg;
    logic [LINK_BITS-1:0] tail_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    logic [IDX_BITS-1:0]  free_idx;
    logic                 free_any;
    logic                 tail_ok;
    logic                 p_ok;
    logic                 n_ok;
    logic                 key_match;
    out_t                 result;

    logic                 key_we;
    logic [KEY_BITS-1:0]  key_rdata;
    logic                 link_we;
    logic [IDX_BITS-1:0]  link_waddr;
    link_t                link_wdata;
    logic [IDX_BITS-1:0]  link_raddr;
    link_t                link_rdata;

    adl_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(ENTRIES)
    ) u_key_ram (
        .aclk (aclk),
        .we   (key_we),
        .waddr(slot_reg),
        .wdata(key_reg),
        .raddr(idx_reg),
        .rdata(key_rdata)
    );

    adl_ram #(
        .WIDTH($bits(link_t)),
        .DEPTH(ENTRIES)
    ) u_link_ram (
        .aclk (aclk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .raddr(link_raddr),
        .rdata(link_rdata)
    );

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    assign free_any  = ~&valid_reg;
    assign tail_ok   = (tail_reg < NONE_LINK);
    assign p_ok      = (p_reg < NONE_LINK);
    assign n_ok      = (n_reg < NONE_LINK);
    assign key_match = valid_reg[idx_reg] && (key_rdata == key_reg);

    always_comb begin
        key_we     = (state_reg == S_APP_WR);
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = idx_reg;
        case (state_reg)
            S_APP_WR: begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = '{next_link: NONE_LINK, prev_link: tail_reg};
                link_raddr = tail_reg[IDX_BITS-1:0];
            end
            S_APP_FIX: begin
                link_we    = tail_ok;
                link_waddr = tail_reg[IDX_BITS-1:0];
                link_wdata = '{next_link: LINK_BITS'(slot_reg),
                               prev_link: link_rdata.prev_link};
            end
            S_UNL_P: begin
                link_raddr = p_reg[IDX_BITS-1:0];
            end
            S_UNL_WP: begin
                link_we    = p_ok;
                link_waddr = p_reg[IDX_BITS-1:0];
                link_wdata = '{next_link: n_reg, prev_link: link_rdata.prev_link};
                link_raddr = n_reg[IDX_BITS-1:0];
            end
            S_UNL_WN: begin
                link_we    = n_ok;
                link_waddr = n_reg[IDX_BITS-1:0];
                link_wdata = '{next_link: link_rdata.next_link, prev_link: p_reg};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.removed_count = removed_reg;
        result.length        = count_reg;
        result.slot          = '0;
        if (mode_reg == MODE_REMOVE) begin
            result.status = (removed_reg == '0) ? ST_NO_MATCH : ST_DONE;
        end else if (full_reg) begin
            result.status = ST_FULL;
        end else begin
            result.status = ST_DONE;
            result.slot   = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            head_reg    <= NONE_LINK;
            tail_reg    <= NONE_LINK;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg    <= s_data.mode;
                        key_reg     <= norm_key(s_data.key_value);
                        idx_reg     <= '0;
                        removed_reg <= '0;
                        slot_reg    <= free_idx;
                        full_reg    <= !free_any;
                        if (s_data.mode == MODE_REMOVE) begin
                            state_reg <= S_SCAN_RD;
                        end else if (!free_any) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_APP_WR;
                        end
                    end
                end
                S_APP_WR: begin
                    state_reg <= S_APP_FIX;
                end
                S_APP_FIX: begin
                    if (!tail_ok) begin
                        head_reg <= LINK_BITS'(slot_reg);
                    end
                    tail_reg            <= LINK_BITS'(slot_reg);
                    valid_reg[slot_reg] <= 1'b1;
                    count_reg           <= count_reg + 1'b1;
                    state_reg           <= S_DONE;
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (key_match) begin
                        p_reg     <= link_rdata.prev_link;
                        n_reg     <= link_rdata.next_link;
                        state_reg <= S_UNL_P;
                    end else if (idx_reg == LAST_IDX) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UNL_P: begin
                    state_reg <= S_UNL_WP;
                end
                S_UNL_WP: begin
                    if (!p_ok) begin
                        head_reg <= n_reg;
                    end
                    state_reg <= S_UNL_WN;
                end
                S_UNL_WN: begin
                    if (!n_ok) begin
                        tail_reg <= p_reg;
                    end
                    valid_reg[idx_reg] <= 1'b0;
                    if (count_reg != '0) begin
                        count_reg <= count_reg - 1'b1;
                    end
                    removed_reg <= removed_reg + 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_DONE: begin
                    // Park the result once the output register is free or being drained.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg <= result;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/adl_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adl_chk (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire adl_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire adl_pkg::out_t m_data
);

    import adl_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Only one item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |->
            m_data.length == CNT_BITS'(ENTRIES) && m_data.removed_count == '0
            && m_data.slot == '0)
        else $error("full result with inconsistent fields");

    a_no_match_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_NO_MATCH |->
            m_data.removed_count == '0 && m_data.slot == '0)
        else $error("no-match result with inconsistent fields");

    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.length <= CNT_BITS'(ENTRIES)
            && m_data.removed_count <= CNT_BITS'(ENTRIES))
        else $error("length or removed count out of range");

endmodule

bind array_doubly_linked_list adl_chk u_adl_chk (.*);

`default_nettype wire
